FILE: design/pobp_pkg.sv
// Package: shared constants and types for the oriented-box penetration pipeline.
package pobp_pkg;

    localparam int DATA_W       = 16;
    localparam int FRAC_BITS_DEF = 8;
    localparam int CFG_W        = 64;
    localparam int CFG_IDX_W    = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0   = 3'd0,
        REG_ROW1   = 3'd1,
        REG_ROW2   = 3'd2,
        REG_ROW3   = 3'd3,
        REG_EXT_X  = 3'd4,
        REG_EXT_Y  = 3'd5,
        REG_EXT_Z  = 3'd6,
        REG_UNUSED = 3'd7
    } cfg_reg_t;

    // Saturate a wide signed value to 16 bits.
    function automatic logic signed [DATA_W-1:0] sat16(input logic signed [47:0] v);
        logic signed [DATA_W-1:0] r;
        begin
            if (v > 48'sd32767)
                r = 16'sh7fff;
            else if (v < -48'sd32768)
                r = 16'sh8000;
            else
                r = v[DATA_W-1:0];
            return r;
        end
    endfunction

endpackage

FILE: design/pobp_xform.sv
// Matrix transform stage: four-row multiply-accumulate, floor shift, saturate.
module pobp_xform #(
    parameter int FRAC_BITS = pobp_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               adv,
    input  logic                               in_valid,
    input  logic [3:0][pobp_pkg::CFG_W-1:0]    rows,
    input  logic signed [2:0][15:0]            vec,
    output logic                               out_valid,
    output logic signed [3:0][15:0]            res
);
    import pobp_pkg::*;

    logic                      valid_reg;
    logic signed [3:0][3:0][32:0] prod_reg;
    logic signed [3:0][15:0]   res_reg;
    logic                      valid2_reg;

    // Products of each matrix entry with the homogeneous vector.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            valid2_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg  <= in_valid;
            valid2_reg <= valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < 3; c++)
                    prod_reg[r][c] <= 33'($signed(rows[r][16*c +: 16]) * $signed(vec[c]));
                prod_reg[r][3] <= 33'(signed'(rows[r][48 +: 16])) <<< FRAC_BITS;
            end
        end
    end

    // Sum, floor shift (arithmetic shift), saturate.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 4; r++)
                res_reg[r] <= sat16(48'((48'($signed(prod_reg[r][0]))
                    + 48'($signed(prod_reg[r][1]))
                    + 48'($signed(prod_reg[r][2]))
                    + 48'($signed(prod_reg[r][3]))) >>> FRAC_BITS));
        end
    end

    assign out_valid = valid2_reg;
    assign res       = res_reg;
endmodule

FILE: design/pobp_wdiv.sv
// Perspective divide: pipelined restoring divider, one quotient bit per stage.
module pobp_wdiv #(
    parameter int FRAC_BITS = pobp_pkg::FRAC_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  logic                     in_valid,
    input  logic signed [3:0][15:0]  in_vec,
    output logic                     out_valid,
    output logic signed [2:0][15:0]  out_vec
);
    import pobp_pkg::*;

    localparam int NUM_W = 16 + FRAC_BITS;
    localparam int STG   = NUM_W;
    localparam int THR   = (1 << FRAC_BITS) / 10000;

    typedef struct packed {
        logic                    use_div;
        logic [2:0]              neg;
        logic [2:0][15:0]        raw;
        logic [15:0]             den;
        logic [2:0][NUM_W-1:0]   rem;
        logic [2:0][NUM_W-1:0]   num;
    } div_st_t;

    div_st_t   st_reg [STG+1];
    logic      v_reg  [STG+1];
    div_st_t   st_next [STG+1];

    // Stage 0 setup: magnitudes and signs.
    always_comb
    begin
        logic [15:0] aw;
        aw = in_vec[3][15] ? 16'(-in_vec[3]) : 16'(in_vec[3]);
        st_next[0].use_div = 17'(aw) > 17'(THR);
        st_next[0].den     = aw;
        for (int c = 0; c < 3; c++)
        begin
            st_next[0].raw[c] = in_vec[c];
            st_next[0].neg[c] = in_vec[c][15] ^ in_vec[3][15];
            st_next[0].num[c] = NUM_W'(in_vec[c][15] ? 17'(-$signed({in_vec[c][15], in_vec[c]}))
                                : 17'({1'b0, in_vec[c]})) << FRAC_BITS;
            st_next[0].rem[c] = '0;
        end
        for (int s = 1; s <= STG; s++)
        begin
            st_next[s] = st_reg[s-1];
            for (int c = 0; c < 3; c++)
            begin
                logic [NUM_W:0] t;
                t = {st_reg[s-1].rem[c], st_reg[s-1].num[c][NUM_W-1]};
                st_next[s].num[c] = {st_reg[s-1].num[c][NUM_W-2:0], 1'b0};
                if (t >= (NUM_W+1)'(st_reg[s-1].den))
                begin
                    st_next[s].rem[c] = NUM_W'(t - (NUM_W+1)'(st_reg[s-1].den));
                    st_next[s].num[c][0] = 1'b1;
                end
                else
                    st_next[s].rem[c] = NUM_W'(t);
            end
        end
    end

    // Advance the divider pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= STG; s++)
                v_reg[s] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s <= STG; s++)
                v_reg[s] <= v_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s <= STG; s++)
                st_reg[s] <= st_next[s];
        end
    end

    // Apply sign, saturate, or pass through.
    always_comb
    begin
        logic signed [NUM_W+1:0] q;
        for (int c = 0; c < 3; c++)
        begin
            q = $signed({2'b00, st_reg[STG].num[c]});
            if (st_reg[STG].neg[c])
                q = -q;
            out_vec[c] = st_reg[STG].use_div ? sat16(48'(q)) : st_reg[STG].raw[c];
        end
    end

    assign out_valid = v_reg[STG];
endmodule

FILE: design/pobp_rank.sv
// Box test, signed depths and axis ranking, in two register stages.
module pobp_rank (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  logic                     in_valid,
    input  logic signed [2:0][15:0]  p,
    input  logic signed [2:0][15:0]  d,
    input  logic signed [2:0][15:0]  ext,
    output logic                     out_valid,
    output logic                     hit,
    output logic [1:0]               first_axis,
    output logic signed [15:0]       first_depth,
    output logic [1:0]               second_axis,
    output logic signed [15:0]       second_depth
);
    import pobp_pkg::*;

    logic                    v1_reg, v2_reg;
    logic [2:0][15:0]        dep_reg;
    logic signed [2:0][15:0] sdep_reg;
    logic                    in_reg;
    logic                    hit_reg;
    logic [1:0]              a0_reg, a1_reg;
    logic signed [15:0]      d0_reg, d1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    // Depths and inside flag.
    always_ff @(posedge clk)
    begin
        logic [16:0] ae, ap, half;
        logic        ok;
        logic        sp, zp, zd;
        if (adv)
        begin
            ok = 1'b1;
            for (int i = 0; i < 3; i++)
            begin
                ae   = ext[i][15] ? 17'(-$signed({ext[i][15], ext[i]})) : 17'(ext[i]);
                half = ae >> 1;
                ap   = p[i][15] ? 17'(-$signed({p[i][15], p[i]})) : 17'(p[i]);
                if (!(ap < half))
                    ok = 1'b0;
                dep_reg[i] <= 16'(half - ap);
                zp = (p[i] == 0);
                zd = (d[i] == 0);
                sp = p[i][15];
                // sign(d)*sign(p*d) = sign(p) when both nonzero
                if (zp || zd)
                    sdep_reg[i] <= '0;
                else if (sp)
                    sdep_reg[i] <= 16'(-(half - ap));
                else
                    sdep_reg[i] <= 16'(half - ap);
            end
            in_reg <= ok;
        end
    end

    // Compare-swap network, lower index kept on ties.
    always_ff @(posedge clk)
    begin
        logic [1:0] ax0, ax1, ax2, t;
        if (adv)
        begin
            ax0 = 2'd0; ax1 = 2'd1; ax2 = 2'd2;
            if (dep_reg[ax0] > dep_reg[ax1]) begin t = ax0; ax0 = ax1; ax1 = t; end
            if (dep_reg[ax0] > dep_reg[ax2]) begin t = ax0; ax0 = ax2; ax2 = t; end
            if (dep_reg[ax1] > dep_reg[ax2]) begin t = ax1; ax1 = ax2; ax2 = t; end
            hit_reg <= in_reg;
            a0_reg  <= in_reg ? ax0 : 2'd0;
            a1_reg  <= in_reg ? ax1 : 2'd0;
            d0_reg  <= in_reg ? sdep_reg[ax0] : 16'sd0;
            d1_reg  <= in_reg ? sdep_reg[ax1] : 16'sd0;
        end
    end

    assign out_valid    = v2_reg;
    assign hit          = hit_reg;
    assign first_axis   = a0_reg;
    assign first_depth  = d0_reg;
    assign second_axis  = a1_reg;
    assign second_depth = d1_reg;

`ifndef SYNTH
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && !hit_reg |-> a0_reg == 2'd0 && d0_reg == 16'sd0 && d1_reg == 16'sd0)
        else $error("miss result not cleared");
    a_axes_differ: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && hit_reg |-> a0_reg != a1_reg && a0_reg != 2'd3 && a1_reg != 2'd3)
        else $error("ranked axes invalid");
    a_valid_chain: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> v2_reg == $past(v1_reg))
        else $error("valid lost in ranking stage");
`endif
endmodule

FILE: design/point_in_oriented_box_penetration.sv
// Point-in-oriented-box penetration test, fully pipelined: one beat per cycle
// while out_ready allows. Each point/direction beat is transformed by the
// configured inverse matrix (two stages), divided by w in a bit-per-stage
// divider (16+FRAC_BITS+1 stages), then box-tested and ranked (two stages).
// A stall freezes the whole pipeline; out_ready low holds the result.
// Configuration may only be written while the pipeline is empty.
module point_in_oriented_box_penetration #(
    parameter int FRAC_BITS = pobp_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pobp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pobp_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [15:0]                  point_x,
    input  logic signed [15:0]                  point_y,
    input  logic signed [15:0]                  point_z,
    input  logic signed [15:0]                  dir_x,
    input  logic signed [15:0]                  dir_y,
    input  logic signed [15:0]                  dir_z,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                hit,
    output logic [1:0]                          first_axis,
    output logic signed [15:0]                  first_depth,
    output logic [1:0]                          second_axis,
    output logic signed [15:0]                  second_depth
);
    import pobp_pkg::*;

    logic [3:0][CFG_W-1:0]   rows_reg;
    logic signed [2:0][15:0] ext_reg;
    logic                    adv;
    logic                    pv, dv, pdv, ddv;
    logic signed [3:0][15:0] pr, dr;
    logic signed [2:0][15:0] pl, dl;

    // Pipeline moves when output register is free or being drained.
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 4; r++)
                rows_reg[r] <= CFG_W'(1) << (16*r + FRAC_BITS);
            for (int i = 0; i < 3; i++)
                ext_reg[i] <= 16'(1 << FRAC_BITS);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ROW0:  rows_reg[0] <= cfg_data;
                REG_ROW1:  rows_reg[1] <= cfg_data;
                REG_ROW2:  rows_reg[2] <= cfg_data;
                REG_ROW3:  rows_reg[3] <= cfg_data;
                REG_EXT_X: ext_reg[0]  <= cfg_data[15:0];
                REG_EXT_Y: ext_reg[1]  <= cfg_data[15:0];
                REG_EXT_Z: ext_reg[2]  <= cfg_data[15:0];
                default:   ;
            endcase
        end
    end

    pobp_xform #(.FRAC_BITS(FRAC_BITS)) u_xp (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(in_valid && in_ready),
        .rows(rows_reg), .vec({point_z, point_y, point_x}),
        .out_valid(pv), .res(pr));

    pobp_xform #(.FRAC_BITS(FRAC_BITS)) u_xd (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(in_valid && in_ready),
        .rows(rows_reg), .vec({dir_z, dir_y, dir_x}),
        .out_valid(dv), .res(dr));

    pobp_wdiv #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(pv),
        .in_vec(pr), .out_valid(pdv), .out_vec(pl));

    pobp_wdiv #(.FRAC_BITS(FRAC_BITS)) u_dd (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(dv),
        .in_vec(dr), .out_valid(ddv), .out_vec(dl));

    pobp_rank u_rank (
        .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(pdv && ddv),
        .p(pl), .d(dl), .ext(ext_reg),
        .out_valid(out_valid), .hit(hit),
        .first_axis(first_axis), .first_depth(first_depth),
        .second_axis(second_axis), .second_depth(second_depth));

`ifndef SYNTH
    a_lanes_align: assert property (@(posedge clk) disable iff (!rst_n) pdv == ddv)
        else $error("point and direction lanes out of step");
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(first_depth))
        else $error("stalled result changed");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("pipeline blocked while empty");
`endif
endmodule
